### rtl/estc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ELF segment table checker: shared types and constants
// Request layouts for both channels, the per-entry check summary passed
// between the check logic and the top level, and the configuration codes.
// ----------------------------------------------------------------------------
package estc_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FILE_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPAN      = 2'd2;

  // Segment kind that is loaded, and the permitted permission bits.
  localparam logic [31:0] LOAD_TYPE = 32'd1;
  localparam logic [31:0] FLAG_MASK = 32'h0000_0007;

  // Default span limit of 16 MiB, and the count ceiling.
  localparam logic [63:0] SPAN_RESET = 64'd16777216;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [63:0] ADDR_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // One program header entry.
  typedef struct packed {
    logic [31:0] segment_type;
    logic [31:0] segment_flags;
    logic [63:0] file_offset;
    logic [63:0] virtual_address;
    logic [63:0] file_bytes;
    logic [63:0] memory_bytes;
    logic [63:0] alignment;
    logic        last_entry;
  } estc_entry_t;

  // One table verdict.
  typedef struct packed {
    logic        table_ok;
    logic [63:0] lowest_address;
    logic [63:0] highest_end;
    logic [15:0] load_count;
  } estc_verdict_t;

  // Summary of the checks on one entry.
  typedef struct packed {
    logic        loadable;
    logic        pass;
    logic [63:0] virtual_address;
    logic [63:0] mem_end;
    logic        last_entry;
  } estc_check_t;

endpackage

### rtl/estc_entry_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entry channel
// Valid/ready channel carrying one program header entry per request.
// ----------------------------------------------------------------------------
interface estc_entry_if;
  logic                 valid;
  logic                 ready;
  estc_pkg::estc_entry_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/estc_verdict_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Verdict channel
// Valid/ready channel carrying one table verdict per request.
// ----------------------------------------------------------------------------
interface estc_verdict_if;
  logic                   valid;
  logic                   ready;
  estc_pkg::estc_verdict_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/estc_entry_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-entry header checks
// Runs every validity check on one registered entry in parallel and
// summarises the outcome, with the memory end of the segment.
// ----------------------------------------------------------------------------
module estc_entry_check (
  input  estc_pkg::estc_entry_t entry,
  input  logic [63:0]           file_length,
  output estc_pkg::estc_check_t chk
);

  logic [64:0] file_stop;
  logic [64:0] mem_end;
  logic [63:0] align_m1;
  logic [63:0] skew;
  logic        flags_bad;
  logic        size_bad;
  logic        file_bad;
  logic        mem_bad;
  logic        align_bad;
  logic        skew_bad;

  // Permission bits beyond read, write and execute.
  assign flags_bad = (entry.segment_flags & ~estc_pkg::FLAG_MASK) != 32'd0;

  // An empty segment, or more file data than memory.
  assign size_bad = (entry.memory_bytes == 64'd0) ||
                    (entry.file_bytes > entry.memory_bytes);

  // The file range must neither wrap nor run past the end of the file.
  assign file_stop = {1'b0, entry.file_offset} + {1'b0, entry.file_bytes};
  assign file_bad  = file_stop[64] || (file_stop[63:0] > file_length);

  // The memory range must not wrap.
  assign mem_end = {1'b0, entry.virtual_address} + {1'b0, entry.memory_bytes};
  assign mem_bad = mem_end[64];

  // Alignment is zero or a power of two.
  assign align_m1  = entry.alignment - 64'd1;
  assign align_bad = (entry.alignment != 64'd0) &&
                     ((entry.alignment & align_m1) != 64'd0);

  // Address and offset must agree modulo a real alignment.
  assign skew     = entry.virtual_address - entry.file_offset;
  assign skew_bad = (entry.alignment > 64'd1) && ((skew & align_m1) != 64'd0);

  always_comb begin
    chk.loadable        = entry.segment_type == estc_pkg::LOAD_TYPE;
    chk.pass            = !(flags_bad || size_bad || file_bad || mem_bad ||
                            align_bad || skew_bad);
    chk.virtual_address = entry.virtual_address;
    chk.mem_end         = mem_end[63:0];
    chk.last_entry      = entry.last_entry;
  end

endmodule

### rtl/elf_segment_table_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ELF segment table checker
// Validates a stream of ELF64 program header entries and reports one
// verdict per table.
// ----------------------------------------------------------------------------
// Usage:
//   in_seg carries one program header entry per request; the entry flagged
//   last_entry closes the table. out_verdict carries one request per table:
//   the pass/fail verdict, lowest address, highest end and loadable count.
//   Entries that are not the last produce no output request.
//   The cfg_ port writes file_length, entry_address and max_span; write it
//   only while no table is in flight.
// Timing:
//   An entry is taken every cycle while in_seg.ready is high. The pipeline
//   is input register, check register, tracker update with verdict
//   snapshot, then output register.
// Reset and stalls:
//   rst_n (synchronous, active low) empties the pipeline, clears the
//   trackers and restores the register defaults (span limit 16 MiB).
//   While out_verdict is stalled, the held verdict waits in the output
//   register and one more in the snapshot stage; entries that do not close
//   a table keep flowing, and in_seg.ready drops only once a further
//   last entry cannot move on.
// ----------------------------------------------------------------------------
module elf_segment_table_checker_top (
  input  logic                                clk,
  input  logic                                rst_n,
  estc_entry_if.sink                          in_seg,
  estc_verdict_if.source                      out_verdict,
  input  logic                                cfg_we,
  input  logic [estc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [estc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [63:0] file_length_r;
  logic [63:0] entry_address_r;
  logic [63:0] max_span_r;

  // Input stage.
  logic                  a_valid_r;
  estc_pkg::estc_entry_t a_entry_r;

  // Check stage.
  logic                  b_valid_r;
  estc_pkg::estc_check_t b_chk_r;
  estc_pkg::estc_check_t chk;

  // Running table state.
  logic [63:0] low_r,    low_nxt,    low_upd;
  logic [63:0] high_r,   high_nxt,   high_upd;
  logic [15:0] count_r,  count_nxt,  count_upd;
  logic        failed_r, failed_nxt, failed_upd;

  // Verdict snapshot stage.
  logic        v_valid_r;
  logic [63:0] v_low_r;
  logic [63:0] v_high_r;
  logic [15:0] v_count_r;
  logic        v_failed_r;

  // Output stage.
  logic                    out_valid_r;
  estc_pkg::estc_verdict_t out_data_r;
  estc_pkg::estc_verdict_t verdict_nxt;

  // Handshake chain.
  logic out_load_ok;
  logic v_adv, v_free;
  logic b_adv, b_free;
  logic a_adv, a_free;
  logic in_take;
  logic close_table;
  logic good;
  logic [63:0] span;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r   <= 64'd0;
      entry_address_r <= 64'd0;
      max_span_r      <= estc_pkg::SPAN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        estc_pkg::REG_FILE_LENGTH:   file_length_r   <= cfg_data;
        estc_pkg::REG_ENTRY_ADDRESS: entry_address_r <= cfg_data;
        estc_pkg::REG_MAX_SPAN:      max_span_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Each stage loads when it is empty or its content moves on. Entries that
  // do not close a table never need the verdict stages.
  assign out_load_ok = !out_valid_r || out_verdict.ready;
  assign v_adv       = v_valid_r && out_load_ok;
  assign v_free      = !v_valid_r || out_load_ok;
  assign b_adv       = b_valid_r && (!b_chk_r.last_entry || v_free);
  assign b_free      = !b_valid_r || b_adv;
  assign a_adv       = a_valid_r && b_free;
  assign a_free      = !a_valid_r || b_free;
  assign in_take     = in_seg.valid && a_free;
  assign in_seg.ready = a_free;
  assign close_table = b_adv && b_chk_r.last_entry;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_free) begin
      a_valid_r <= in_seg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_entry_r <= in_seg.data;
    end
  end

  estc_entry_check u_check (
    .entry       (a_entry_r),
    .file_length (file_length_r),
    .chk         (chk)
  );

  // Check register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_free) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_chk_r <= chk;
    end
  end

  // Fold a checked entry into the trackers; a failing loadable entry only
  // marks the table as failed.
  always_comb begin
    good       = b_adv && b_chk_r.loadable && b_chk_r.pass;
    low_upd    = (good && (b_chk_r.virtual_address < low_r)) ?
                 b_chk_r.virtual_address : low_r;
    high_upd   = (good && (b_chk_r.mem_end > high_r)) ? b_chk_r.mem_end : high_r;
    count_upd  = (good && (count_r != estc_pkg::COUNT_MAX)) ?
                 count_r + 16'd1 : count_r;
    failed_upd = failed_r || (b_adv && b_chk_r.loadable && !b_chk_r.pass);
    if (close_table) begin
      low_nxt    = estc_pkg::ADDR_ALL_ONES;
      high_nxt   = 64'd0;
      count_nxt  = 16'd0;
      failed_nxt = 1'b0;
    end else begin
      low_nxt    = low_upd;
      high_nxt   = high_upd;
      count_nxt  = count_upd;
      failed_nxt = failed_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r    <= estc_pkg::ADDR_ALL_ONES;
      high_r   <= 64'd0;
      count_r  <= 16'd0;
      failed_r <= 1'b0;
    end else begin
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      count_r  <= count_nxt;
      failed_r <= failed_nxt;
    end
  end

  // Snapshot of the table as it stands after its last entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_valid_r <= 1'b0;
    end else if (v_free) begin
      v_valid_r <= close_table;
    end
  end

  always_ff @(posedge clk) begin
    if (close_table) begin
      v_low_r    <= low_upd;
      v_high_r   <= high_upd;
      v_count_r  <= count_upd;
      v_failed_r <= failed_upd;
    end
  end

  // Pass: no failure, a load, entry point in a non-empty span within limit.
  assign span = v_high_r - v_low_r;

  always_comb begin
    verdict_nxt.table_ok       = !v_failed_r && (v_count_r != 16'd0) &&
                                 (entry_address_r >= v_low_r) &&
                                 (entry_address_r < v_high_r) &&
                                 (v_high_r > v_low_r) && (span <= max_span_r);
    verdict_nxt.lowest_address = v_low_r;
    verdict_nxt.highest_end    = v_high_r;
    verdict_nxt.load_count     = v_count_r;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load_ok) begin
      out_valid_r <= v_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v_adv) begin
      out_data_r <= verdict_nxt;
    end
  end

  assign out_verdict.valid = out_valid_r;
  assign out_verdict.data  = out_data_r;

  // A passing verdict always describes a non-empty span and a loadable entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.table_ok |->
      (out_data_r.lowest_address < out_data_r.highest_end) &&
      (out_data_r.load_count != 16'd0))
    else $error("passing verdict with an empty span or no loadable entry");

  // Closing a table leaves the trackers at their cleared values.
  assert property (@(posedge clk) disable iff (!rst_n)
    close_table |=> (count_r == 16'd0) && !failed_r && (high_r == 64'd0) &&
                    (low_r == estc_pkg::ADDR_ALL_ONES))
    else $error("table state not cleared after the last entry");

  // Failure stays set until the table closes.
  assert property (@(posedge clk) disable iff (!rst_n)
    failed_r && !close_table |=> failed_r)
    else $error("failure flag dropped inside a table");

  // The loadable count saturates rather than wrapping.
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == estc_pkg::COUNT_MAX) && !close_table |=>
      count_r == estc_pkg::COUNT_MAX)
    else $error("loadable count wrapped");

  // A new verdict only follows a snapshot in the stage before.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v_valid_r))
    else $error("verdict raised without a snapshot");

endmodule

### tb/sv/estc_verdict_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ELF segment table checker: verdict monitor
// Watches the entry and verdict channels and the configuration port. It keeps
// its own copy of the registers and of the per-table trackers, works out the
// verdict that each closing entry must produce, and compares every verdict
// request that leaves the block, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
module estc_verdict_monitor (
  input  logic                            clk,
  input  logic                            rst_n,
  estc_entry_if                           seg_mon,
  estc_verdict_if                         verdict_mon,
  input  logic                            cfg_we,
  input  logic [estc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [estc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                     mismatch_count,
  output int unsigned                     verdicts_waiting
);

  localparam int unsigned REPORT_LIMIT = 10;

  // Register copies.
  logic [63:0] file_len_q;
  logic [63:0] entry_addr_q;
  logic [63:0] span_limit_q;

  // Trackers of the table currently being read.
  logic [63:0] low_q;
  logic [63:0] high_q;
  logic [15:0] count_q;
  logic        failed_q;

  // Verdicts owed by the block, oldest first.
  estc_pkg::estc_verdict_t expected_verdicts[$];

  // Checks one loadable entry on its own; mem_end is its memory end.
  function automatic logic segment_is_sound(input estc_pkg::estc_entry_t e,
                                            input logic [63:0] flen,
                                            output logic [63:0] mem_end);
    logic [64:0] file_stop;
    logic [64:0] mem_sum;
    logic [63:0] al;
    logic        sound;
    file_stop = {1'b0, e.file_offset} + {1'b0, e.file_bytes};
    mem_sum   = {1'b0, e.virtual_address} + {1'b0, e.memory_bytes};
    mem_end   = mem_sum[63:0];
    al        = e.alignment;
    sound     = 1'b1;
    if ((e.segment_flags & ~estc_pkg::FLAG_MASK) != 32'd0) sound = 1'b0;
    if (e.memory_bytes == 64'd0 || e.file_bytes > e.memory_bytes) sound = 1'b0;
    if (file_stop[64] || file_stop[63:0] > flen) sound = 1'b0;
    if (mem_sum[64]) sound = 1'b0;
    if (al != 64'd0 && (al & (al - 64'd1)) != 64'd0) sound = 1'b0;
    if (al > 64'd1 &&
        ((e.virtual_address - e.file_offset) & (al - 64'd1)) != 64'd0) begin
      sound = 1'b0;
    end
    return sound;
  endfunction

  always @(posedge clk) begin
    estc_pkg::estc_verdict_t want;
    estc_pkg::estc_verdict_t got;
    logic [63:0]             lo;
    logic [63:0]             hi;
    logic [63:0]             seg_end;
    logic [15:0]             cnt;
    logic                    bad;
    logic                    sound;
    if (!rst_n) begin
      file_len_q       <= '0;
      entry_addr_q     <= '0;
      span_limit_q     <= estc_pkg::SPAN_RESET;
      low_q            <= estc_pkg::ADDR_ALL_ONES;
      high_q           <= '0;
      count_q          <= '0;
      failed_q         <= 1'b0;
      mismatch_count   <= 0;
      verdicts_waiting <= 0;
      expected_verdicts.delete();
    end else begin
      // Register writes.
      if (cfg_we) begin
        case (cfg_index)
          estc_pkg::REG_FILE_LENGTH: begin
            file_len_q <= cfg_data;
          end
          estc_pkg::REG_ENTRY_ADDRESS: begin
            entry_addr_q <= cfg_data;
          end
          estc_pkg::REG_MAX_SPAN: begin
            span_limit_q <= cfg_data;
          end
          default: begin
          end
        endcase
      end

      // Accepted entry: update the trackers and, on the closing entry,
      // record the verdict it owes.
      if (seg_mon.valid && seg_mon.ready) begin
        lo  = low_q;
        hi  = high_q;
        cnt = count_q;
        bad = failed_q;
        if (seg_mon.data.segment_type == estc_pkg::LOAD_TYPE) begin
          sound = segment_is_sound(seg_mon.data, file_len_q, seg_end);
          if (sound) begin
            if (seg_mon.data.virtual_address < lo) lo = seg_mon.data.virtual_address;
            if (seg_end > hi) hi = seg_end;
            if (cnt != estc_pkg::COUNT_MAX) cnt = cnt + 16'd1;
          end else begin
            bad = 1'b1;
          end
        end
        if (seg_mon.data.last_entry) begin
          want.table_ok = !bad && cnt != 16'd0 &&
                          entry_addr_q >= lo && entry_addr_q < hi &&
                          hi > lo && (hi - lo) <= span_limit_q;
          want.lowest_address = lo;
          want.highest_end    = hi;
          want.load_count     = cnt;
          expected_verdicts.push_back(want);
          lo  = estc_pkg::ADDR_ALL_ONES;
          hi  = '0;
          cnt = '0;
          bad = 1'b0;
        end
        low_q    <= lo;
        high_q   <= hi;
        count_q  <= cnt;
        failed_q <= bad;
      end

      // Departing verdict: compare with the oldest one owed.
      if (verdict_mon.valid && verdict_mon.ready) begin
        got = verdict_mon.data;
        if (expected_verdicts.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("verdict with none owed: ok=%0b low=%h high=%h count=%0d",
                     got.table_ok, got.lowest_address, got.highest_end, got.load_count);
          end
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_verdicts.pop_front();
          if (got.table_ok !== want.table_ok ||
              got.lowest_address !== want.lowest_address ||
              got.highest_end !== want.highest_end ||
              got.load_count !== want.load_count) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $display("verdict wrong: wanted ok=%0b low=%h high=%h count=%0d",
                       want.table_ok, want.lowest_address, want.highest_end,
                       want.load_count);
              $display("               got    ok=%0b low=%h high=%h count=%0d",
                       got.table_ok, got.lowest_address, got.highest_end,
                       got.load_count);
            end
            mismatch_count <= mismatch_count + 1;
          end
        end
      end

      verdicts_waiting <= expected_verdicts.size();
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ELF segment table checker: testbench top
// Drives program header tables into the block with random gaps and stalls:
// a short directed set of edge cases, then random phases under several
// register settings.
// The verdict monitor predicts and checks; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned HALF_PERIOD     = 6;
  localparam int unsigned RESET_CYCLES    = 12;
  localparam int unsigned SETTLE_CYCLES   = 10;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS     = 100;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                            cfg_we    = 1'b0;
  logic [estc_pkg::CFG_IDX_W-1:0]  cfg_index = estc_pkg::REG_FILE_LENGTH;
  logic [estc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  int unsigned mismatch_total;
  int unsigned verdicts_pending;
  int unsigned cycle_count = 0;

  // Set for stretches in which neither side idles.
  logic steady     = 1'b0;
  logic table_open = 1'b0;

  // Register values last written, used to shape the stimulus.
  logic [63:0] cur_flen  = '0;
  logic [63:0] cur_entry = '0;
  logic [63:0] cur_span  = estc_pkg::SPAN_RESET;

  estc_entry_if   seg_ch ();
  estc_verdict_if verdict_ch ();

  initial begin
    seg_ch.valid     = 1'b0;
    seg_ch.data      = '0;
    verdict_ch.ready = 1'b0;
  end

  elf_segment_table_checker_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_seg      (seg_ch),
    .out_verdict (verdict_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  estc_verdict_monitor verdict_monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .seg_mon          (seg_ch),
    .verdict_mon      (verdict_ch),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_total),
    .verdicts_waiting (verdicts_pending)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Verdict receiver: a random stall before each request.
  initial begin : verdict_sink
    int unsigned stall;
    logic        took;
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        verdict_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      verdict_ch.ready <= 1'b1;
      do begin
        @(negedge clk);
        took = verdict_ch.valid;
        @(posedge clk);
      end while (!took);
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic estc_pkg::estc_entry_t make_entry(input logic [31:0] kind,
                                                       input logic [31:0] flags,
                                                       input logic [63:0] off,
                                                       input logic [63:0] va,
                                                       input logic [63:0] fsz,
                                                       input logic [63:0] msz,
                                                       input logic [63:0] al,
                                                       input logic        last);
    estc_pkg::estc_entry_t e;
    e.segment_type    = kind;
    e.segment_flags   = flags;
    e.file_offset     = off;
    e.virtual_address = va;
    e.file_bytes      = fsz;
    e.memory_bytes    = msz;
    e.alignment       = al;
    e.last_entry      = last;
    return e;
  endfunction

  // A loadable entry that passes every check, placed near the entry point.
  function automatic estc_pkg::estc_entry_t sound_entry();
    logic [63:0] spread, d, va, msz, fsz, lim, base, al, mask, off;
    int unsigned k;
    spread = cur_span >> 2;
    if (spread == 64'd0) spread = 64'hFF;
    if (spread > 64'h40_0000) spread = 64'h40_0000;
    d = rand_word() % spread;
    if ($urandom_range(0, 2) == 0) begin
      va = (cur_entry + d < cur_entry) ? cur_entry : cur_entry + d;
    end else begin
      va = (cur_entry >= d) ? cur_entry - d : 64'd0;
    end
    msz = 64'd1 + rand_word() % (spread + d);
    if (msz > ~va) msz = ~va;
    if (msz == 64'd0) begin
      va  = va - 64'd1;
      msz = 64'd1;
    end
    fsz = ($urandom_range(0, 3) == 0) ? 64'd0 : rand_word() % (msz + 64'd1);
    if (fsz > cur_flen) fsz = cur_flen;
    lim  = cur_flen - fsz;
    k    = $urandom_range(0, 22);
    al   = (k == 0) ? 64'd0 : (64'd1 << (k - 1));
    mask = (al > 64'd1) ? al - 64'd1 : 64'd0;
    base = (lim == estc_pkg::ADDR_ALL_ONES) ? rand_word() : rand_word() % (lim + 64'd1);
    // Keep the offset congruent to the address, or drop the alignment.
    off  = (base & ~mask) | (va & mask);
    if (off > lim) begin
      if ((base & ~mask) >= al && al > 64'd1) begin
        off = off - al;
      end else begin
        al  = 64'd0;
        off = base;
      end
    end
    return make_entry(estc_pkg::LOAD_TYPE, $urandom_range(0, 7), off, va, fsz, msz, al,
                      1'b0);
  endfunction

  // A loadable entry broken by one chosen fault.
  function automatic estc_pkg::estc_entry_t faulty_entry();
    estc_pkg::estc_entry_t e;
    logic [63:0] al;
    int unsigned k;
    e = sound_entry();
    case ($urandom_range(0, 7))
      0: e.segment_flags = e.segment_flags | (32'd1 << $urandom_range(3, 31));
      1: e.memory_bytes = 64'd0;
      2: e.file_bytes = e.memory_bytes + 64'd1 + $urandom_range(0, 255);
      3: begin
        e.file_offset = estc_pkg::ADDR_ALL_ONES - $urandom_range(0, 7);
        e.file_bytes  = 64'd16;
        if (e.memory_bytes < 64'd16) e.memory_bytes = 64'd16;
      end
      4: e.file_offset = cur_flen - e.file_bytes + 64'd1 + $urandom_range(0, 15);
      5: e.virtual_address = ~e.memory_bytes + 64'd1 + $urandom_range(0, 15);
      6: e.alignment = 64'h3 << $urandom_range(0, 62);
      default: begin
        k  = $urandom_range(1, 16);
        al = 64'd1 << k;
        e.alignment   = al;
        e.file_offset = (e.file_offset & ~(al - 64'd1)) |
                        ((e.virtual_address + $urandom_range(1, (32'd1 << k) - 1)) &
                         (al - 64'd1));
      end
    endcase
    return e;
  endfunction

  // Fully random content: every bit of every field gets exercised.
  function automatic estc_pkg::estc_entry_t noise_entry();
    estc_pkg::estc_entry_t e;
    e = make_entry($urandom, $urandom, rand_word(), rand_word(), rand_word(),
                   rand_word(), rand_word(), $urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1) == 0) e.segment_type = estc_pkg::LOAD_TYPE;
    if ($urandom_range(0, 1) == 0) e.segment_flags = $urandom_range(0, 7);
    return e;
  endfunction

  // An entry that is not loadable.
  function automatic estc_pkg::estc_entry_t skipped_entry();
    estc_pkg::estc_entry_t e;
    e = noise_entry();
    if (e.segment_type == estc_pkg::LOAD_TYPE) e.segment_type = 32'd0;
    e.last_entry = 1'b0;
    return e;
  endfunction

  // Sends one request; valid stays high afterwards for a back-to-back entry.
  task automatic send_entry(input estc_pkg::estc_entry_t e);
    int unsigned gap;
    logic        took;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      seg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg_ch.valid <= 1'b1;
    seg_ch.data  <= e;
    do begin
      @(negedge clk);
      took = seg_ch.ready;
      @(posedge clk);
    end while (!took);
    table_open = !e.last_entry;
  endtask

  // Stops sending and waits for every owed verdict to arrive.
  task automatic wait_drained();
    seg_ch.valid <= 1'b0;
    do @(negedge clk); while (verdicts_pending != 0);
    @(posedge clk);
  endtask

  // Closes any open table, drains, and lets the pipeline empty.
  task automatic settle();
    if (table_open) send_entry(make_entry(32'd0, 32'd0, '0, '0, '0, '0, '0, 1'b1));
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [63:0] flen, input logic [63:0] entry_va,
                            input logic [63:0] span);
    cfg_we    <= 1'b1;
    cfg_index <= estc_pkg::REG_FILE_LENGTH;
    cfg_data  <= flen;
    @(posedge clk);
    cfg_index <= estc_pkg::REG_ENTRY_ADDRESS;
    cfg_data  <= entry_va;
    @(posedge clk);
    cfg_index <= estc_pkg::REG_MAX_SPAN;
    cfg_data  <= span;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    cur_flen  = flen;
    cur_entry = entry_va;
    cur_span  = span;
  endtask

  // Mostly well-formed tables, with noise entries and early drains mixed in.
  task automatic run_random(input int unsigned target);
    int unsigned sent;
    int unsigned n;
    int unsigned pick;
    estc_pkg::estc_entry_t e;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 9) == 0) steady = !steady;
      if ($urandom_range(0, 9) < 7) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          pick = $urandom_range(0, 9);
          if (pick < 7) e = sound_entry();
          else if (pick == 7) e = skipped_entry();
          else e = faulty_entry();
          e.last_entry = (i == n - 1);
          send_entry(e);
          sent++;
        end
      end else begin
        e = noise_entry();
        send_entry(e);
        sent++;
      end
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
  endtask

  initial begin : stimulus
    logic [63:0] flen, entry_va, span;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults: only an empty file range fits.
    send_entry(make_entry(estc_pkg::LOAD_TYPE, 32'd4, 64'd0, 64'd0, 64'd0, 64'h100,
                          64'd0, 1'b1));
    send_entry(make_entry(estc_pkg::LOAD_TYPE, 32'd6, 64'd0, 64'd0, 64'd1, 64'h100,
                          64'd1, 1'b1));
    settle();

    write_regs(64'h10_0000, 64'h40_1000, estc_pkg::SPAN_RESET);
    // A clean single-segment table.
    send_entry(make_entry(estc_pkg::LOAD_TYPE, 32'd5, 64'h1000, 64'h40_1000, 64'h800,
                          64'h2000, 64'h1000, 1'b1));
    // Sticky failure, later sound entries still tracked, closing entry skipped.
    send_entry(skipped_entry());
    send_entry(make_entry(estc_pkg::LOAD_TYPE, 32'd4, 64'd0, 64'h40_0000, 64'h100,
                          64'h1000, 64'd0, 1'b0));
    send_entry(make_entry(estc_pkg::LOAD_TYPE, 32'd8, 64'd0, 64'h40_0000, 64'd0, 64'h10,
                          64'd0, 1'b0));
    send_entry(make_entry(estc_pkg::LOAD_TYPE, 32'd6, 64'h2000, 64'h40_3000, 64'h100,
                          64'h4000, 64'h1000, 1'b0));
    send_entry(make_entry(32'd0, 32'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 1'b1));
    // A table with no loadable entry.
    send_entry(make_entry(32'd2, 32'd7, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 1'b1));
    // Each way a single entry can fail, but for bad flags.
    send_entry(make_entry(estc_pkg::LOAD_TYPE, 32'd4, 64'd0, 64'h40_1000, 64'd0, 64'd0,
                          64'd0, 1'b1));
    send_entry(make_entry(estc_pkg::LOAD_TYPE, 32'd4, 64'd0, 64'h40_1000, 64'h11,
                          64'h10, 64'd0, 1'b1));
    send_entry(make_entry(estc_pkg::LOAD_TYPE, 32'd4, estc_pkg::ADDR_ALL_ONES,
                          64'h40_1000, 64'd2, 64'h10, 64'd0, 1'b1));
    send_entry(make_entry(estc_pkg::LOAD_TYPE, 32'd4, 64'h10_0000 - 64'h10, 64'h40_1000,
                          64'h11, 64'h20, 64'd0, 1'b1));
    send_entry(make_entry(estc_pkg::LOAD_TYPE, 32'd4, 64'd0,
                          estc_pkg::ADDR_ALL_ONES - 64'hF, 64'd0, 64'h10, 64'd0, 1'b1));
    send_entry(make_entry(estc_pkg::LOAD_TYPE, 32'd4, 64'd0, 64'h40_1000, 64'd0, 64'h10,
                          64'd3, 1'b1));
    send_entry(make_entry(estc_pkg::LOAD_TYPE, 32'd4, 64'h10, 64'h40_1000, 64'd0, 64'h10,
                          64'h1000, 1'b1));
    // File range ending exactly at the file length, entry point at the low end.
    send_entry(make_entry(estc_pkg::LOAD_TYPE, 32'd7, 64'h10_0000 - 64'h100, 64'h40_1000,
                          64'h100, 64'h100, 64'd1, 1'b1));
    // Entry point exactly at the high end.
    send_entry(make_entry(estc_pkg::LOAD_TYPE, 32'd4, 64'd0, 64'h40_0000, 64'd0,
                          64'h1000, 64'd0, 1'b1));
    // Span one page over the limit, then exactly at it.
    send_entry(make_entry(estc_pkg::LOAD_TYPE, 32'd4, 64'd0, 64'h40_0000, 64'd0,
                          64'h2000, 64'd0, 1'b0));
    send_entry(make_entry(estc_pkg::LOAD_TYPE, 32'd4, 64'd0,
                          64'h40_0000 + estc_pkg::SPAN_RESET, 64'd0, 64'h1000, 64'd0,
                          1'b1));
    send_entry(make_entry(estc_pkg::LOAD_TYPE, 32'd4, 64'd0, 64'h40_0000, 64'd0,
                          64'h2000, 64'd0, 1'b0));
    send_entry(make_entry(estc_pkg::LOAD_TYPE, 32'd4, 64'd0,
                          64'h40_0000 + estc_pkg::SPAN_RESET - 64'h1000, 64'd0,
                          64'h1000, 64'd0, 1'b1));
    settle();

    // Random phases, each under its own register setting.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          flen = estc_pkg::ADDR_ALL_ONES;
          entry_va = estc_pkg::ADDR_ALL_ONES - 64'hFFFF;
          span = estc_pkg::ADDR_ALL_ONES;
        end
        1: begin
          flen = '0;
          entry_va = '0;
          span = '0;
        end
        2: begin
          flen = rand_word();
          entry_va = rand_word();
          span = estc_pkg::SPAN_RESET;
        end
        3: begin
          flen = $urandom_range(0, 32'h10_0000);
          entry_va = $urandom;
          span = $urandom_range(0, 32'h1_0000);
        end
        default: begin
          flen = rand_word();
          entry_va = rand_word();
          span = ($urandom_range(0, 1) == 0) ? rand_word() :
                 rand_word() >> $urandom_range(0, 63);
        end
      endcase
      write_regs(flen, entry_va, span);
      steady = ($urandom_range(0, 3) == 0);
      run_random(PHASE_ITEMS);
      settle();
    end

    if (mismatch_total == 0 && verdicts_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
